FILE: src/rbr_pkg.sv
`default_nettype none
package rbr_pkg;

  localparam int OVERSAMPLE_DEFAULT = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam int CODE_W = 5;
  localparam int CHAR_W = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_RX_INVERT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIGURES_VARIANT = 1'b1;

  localparam logic [1:0] FIG_GERMAN = 2'd0;
  localparam logic [1:0] FIG_BRITISH = 2'd1;
  localparam logic [1:0] FIG_US = 2'd2;

  localparam logic [CODE_W-1:0] CODE_FIGS = 5'd27;
  localparam logic [CODE_W-1:0] CODE_LTRS = 5'd31;

  typedef struct packed {
    logic valid;
    logic [CODE_W-1:0] code;
  } frame_push_t;

  typedef struct packed {
    logic valid;
    logic [CODE_W-1:0] code;
  } queue_head_t;

  localparam logic [CHAR_W-1:0] LETTERS_TABLE [0:31] = '{
    8'h00, 8'h45, 8'h0A, 8'h41, 8'h20, 8'h53, 8'h49, 8'h55,
    8'h0D, 8'h44, 8'h52, 8'h4A, 8'h4E, 8'h46, 8'h43, 8'h4B,
    8'h54, 8'h5A, 8'h4C, 8'h57, 8'h48, 8'h59, 8'h50, 8'h51,
    8'h4F, 8'h42, 8'h47, 8'h00, 8'h4D, 8'h58, 8'h56, 8'h00
  };

  localparam logic [CHAR_W-1:0] GERMAN_TABLE [0:31] = '{
    8'h00, 8'h33, 8'h0A, 8'h2D, 8'h20, 8'h27, 8'h38, 8'h37,
    8'h0D, 8'h24, 8'h34, 8'hDF, 8'h2C, 8'hC4, 8'h3A, 8'h28,
    8'h35, 8'h2B, 8'h29, 8'h32, 8'hDC, 8'h36, 8'h30, 8'h31,
    8'h39, 8'h3F, 8'hD6, 8'h00, 8'h2E, 8'h2F, 8'h3D, 8'h00
  };

  localparam logic [CHAR_W-1:0] BRITISH_TABLE [0:31] = '{
    8'h00, 8'h33, 8'h0A, 8'h2D, 8'h20, 8'h27, 8'h38, 8'h37,
    8'h0D, 8'h24, 8'h34, 8'h07, 8'h2C, 8'h25, 8'h3A, 8'h28,
    8'h35, 8'h2B, 8'h29, 8'h32, 8'h23, 8'h36, 8'h30, 8'h31,
    8'h39, 8'h3F, 8'h40, 8'h00, 8'h2E, 8'h2F, 8'h3D, 8'h00
  };

  localparam logic [CHAR_W-1:0] US_TABLE [0:31] = '{
    8'h00, 8'h33, 8'h0A, 8'h2D, 8'h20, 8'h07, 8'h38, 8'h37,
    8'h0D, 8'h24, 8'h34, 8'h27, 8'h2C, 8'h21, 8'h3A, 8'h28,
    8'h35, 8'h22, 8'h29, 8'h32, 8'h2A, 8'h36, 8'h30, 8'h31,
    8'h39, 8'h3F, 8'h26, 8'h00, 8'h2E, 8'h2F, 8'h3B, 8'h00
  };

endpackage
`default_nettype wire

FILE: src/rbr_front.sv
`default_nettype none
module rbr_front #(
  parameter int OVERSAMPLE = rbr_pkg::OVERSAMPLE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               line_level,
  input  logic               rx_invert,
  input  logic               queue_full,
  output rbr_pkg::frame_push_t push
);
  import rbr_pkg::*;

  localparam int EDGE_AGE = 6 * OVERSAMPLE + OVERSAMPLE / 2;
  localparam int HIST_LEN = EDGE_AGE + 2;
  localparam int BLANK_LEN = 6 * OVERSAMPLE;
  localparam int BLANK_W = $clog2(BLANK_LEN + 1);

  logic [HIST_LEN-1:0] history;
  logic [HIST_LEN-1:0] history_next;
  logic [BLANK_W-1:0]  blank_count;
  logic [5:0]          frame;
  logic                accept;
  logic                start_edge;
  logic                good;

  assign in_stall = queue_full;
  assign accept = in_valid && !in_stall;
  assign history_next = {history[HIST_LEN-2:0], line_level};

  assign start_edge = (history_next[EDGE_AGE+1] ^ rx_invert) &&
                      !(history_next[EDGE_AGE] ^ rx_invert);

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      frame[k] = history_next[(5 - k) * OVERSAMPLE] ^ rx_invert;
    end
  end

  assign good = accept && (blank_count == '0) && start_edge && frame[5];
  assign push.valid = good;
  assign push.code = frame[CODE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '1;
      blank_count <= '0;
    end else if (accept) begin
      history <= history_next;
      if (blank_count != '0) begin
        blank_count <= blank_count - 1'b1;
      end else if (good) begin
        blank_count <= BLANK_W'(BLANK_LEN);
      end
    end
  end

  a_blank_loaded: assert property (@(posedge clk) disable iff (rst)
    good |=> blank_count == BLANK_W'(BLANK_LEN))
    else $error("Blanking period was not started after a frame.");

  a_no_frame_while_blank: assert property (@(posedge clk) disable iff (rst)
    (blank_count != '0) |-> !push.valid)
    else $error("Frame detected during blanking.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !push.valid)
    else $error("Frame pushed into a full queue.");

endmodule
`default_nettype wire

FILE: src/rbr_queue.sv
`default_nettype none
module rbr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  rbr_pkg::frame_push_t push,
  input  logic                 pop,
  output logic                 full,
  output rbr_pkg::queue_head_t head
);
  import rbr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CODE_W-1:0]  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full = (count == COUNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.code = mem[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("Queue occupancy out of range.");

endmodule
`default_nettype wire

FILE: src/rbr_back.sv
`default_nettype none
module rbr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  rbr_pkg::queue_head_t       head,
  output logic                       pop,
  input  logic [1:0]                 figures_variant,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rbr_pkg::CODE_W-1:0] baudot_code,
  output logic [rbr_pkg::CHAR_W-1:0] character,
  output logic                       is_shift,
  output logic                       figures_case
);
  import rbr_pkg::*;

  logic              in_figures;
  logic              in_figures_next;
  logic [CHAR_W-1:0] char_next;
  logic [CHAR_W-1:0] fig_char;
  logic              shift_next;

  assign pop = head.valid && (!out_valid || !out_stall);

  always_comb begin
    unique case (figures_variant)
      FIG_GERMAN:  fig_char = GERMAN_TABLE[head.code];
      FIG_BRITISH: fig_char = BRITISH_TABLE[head.code];
      default:     fig_char = US_TABLE[head.code];
    endcase
  end

  always_comb begin
    in_figures_next = in_figures;
    shift_next = 1'b0;
    char_next = '0;
    priority if (head.code == CODE_FIGS) begin
      in_figures_next = 1'b1;
      shift_next = 1'b1;
    end else if (head.code == CODE_LTRS) begin
      in_figures_next = 1'b0;
      shift_next = 1'b1;
    end else if (in_figures) begin
      char_next = fig_char;
    end else begin
      char_next = LETTERS_TABLE[head.code];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      in_figures <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
      in_figures <= in_figures_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      baudot_code <= head.code;
      character <= char_next;
      is_shift <= shift_next;
      figures_case <= in_figures_next;
    end
  end

  a_shift_no_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_shift) |-> (character == '0))
    else $error("Shift code delivered with a nonzero character.");

  a_case_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (figures_case == in_figures))
    else $error("Reported case differs from the held case.");

endmodule
`default_nettype wire

FILE: src/rtty_baudot_receiver_unit.sv
// Accepts one line level per clock cycle; in_stall rises only when the two-entry
// frame queue is full because the output side has held out_stall.
// A frame completed by an accepted line level is written into the queue and
// is then registered onto the outputs once out_valid is low or out_stall is low.
// Synchronous active-high reset clears the line history to mark, the blanking
// counter, the letters/figures case, the queue and both configuration registers.
`default_nettype none
module rtty_baudot_receiver_unit #(
  parameter int OVERSAMPLE = rbr_pkg::OVERSAMPLE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           line_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rbr_pkg::CODE_W-1:0]     baudot_code,
  output logic [rbr_pkg::CHAR_W-1:0]     character,
  output logic                           is_shift,
  output logic                           figures_case,
  input  logic                           cfg_we,
  input  logic [rbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rbr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rbr_pkg::*;

  logic        rx_invert;
  logic [1:0]  figures_variant;
  logic        queue_full;
  logic        pop;
  frame_push_t push;
  queue_head_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_invert <= 1'b0;
      figures_variant <= FIG_GERMAN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RX_INVERT:       rx_invert <= cfg_data[0];
        CFG_FIGURES_VARIANT: figures_variant <= cfg_data[1:0];
        default:             rx_invert <= rx_invert;
      endcase
    end
  end

  rbr_front #(
    .OVERSAMPLE(OVERSAMPLE)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .line_level(line_level),
    .rx_invert(rx_invert),
    .queue_full(queue_full),
    .push(push)
  );

  rbr_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .pop(pop),
    .full(queue_full),
    .head(head)
  );

  rbr_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .pop(pop),
    .figures_variant(figures_variant),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .baudot_code(baudot_code),
    .character(character),
    .is_shift(is_shift),
    .figures_case(figures_case)
  );

endmodule
`default_nettype wire
